// ===== hw/rtl/agr_pkg.sv =====
`default_nettype none

package agr_pkg;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned GroupSizeW  = 5;
  localparam logic [GroupSizeW-1:0] GroupSizeReset = 5'd3;

  typedef enum logic {
    StAccept,
    StDrain
  } state_e;

  // Shift control for the stack cells: push moves towards the tail, pop towards the head
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/agr_cell.sv =====
`default_nettype none

module agr_cell
  import agr_pkg::*;
(
  input  wire  logic              clk_i,
  input  wire  stack_op_t         op_i,
  input  wire  logic [ValueW-1:0] prev_i,
  input  wire  logic [ValueW-1:0] next_i,
  output logic       [ValueW-1:0] value_o
);

  logic [ValueW-1:0] value_q;
  logic [ValueW-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (op_i.push) begin
      value_d = prev_i;
    end else if (op_i.pop) begin
      value_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== hw/rtl/alternate_group_reverser_unit.sv =====
// Pass-through item: result in the output register in the cycle after its transaction.
// Reversing group: items are taken one per cycle while the output slot is free; the closing
// transaction starts a drain that gives one result per cycle while the output slot is free,
// newest first, from the head of the cell chain. Input is held off during a drain.
// The drain length is the item count captured when the group closes.
// Reset (rst_ni low, asynchronous) clears phase, count and output valid; group_size is 3.
`default_nettype none

module alternate_group_reverser_unit
  import agr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  logic                     cfg_we_i,
  input  wire  logic [GroupSizeW-1:0]    cfg_wdata_i,
  input  wire  logic                     in_valid_i,
  output logic                           in_ready_o,
  input  wire  logic signed [ValueW-1:0] item_value_i,
  input  wire  logic                     list_end_i,
  output logic                           out_valid_o,
  input  wire  logic                     out_ready_i,
  output logic signed [ValueW-1:0]       out_value_o,
  output logic                           run_last_o,
  output logic                           out_list_end_o
);

  localparam int unsigned CntW = $clog2(MAX_GROUP + 1);
  localparam int unsigned CmpW = (CntW > GroupSizeW) ? CntW : GroupSizeW;
  localparam logic [CmpW-1:0] MaxGroupC = CmpW'(MAX_GROUP);
  localparam logic [CmpW-1:0] OneC      = CmpW'(1);

  state_e            state_q, state_d;
  logic [GroupSizeW-1:0] size_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   remain_q, remain_d;
  logic              phase_q, phase_d;
  logic              end_flag_q, end_flag_d;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic              run_last_q, run_last_d;
  logic              out_end_q, out_end_d;

  logic              slot_free;
  logic              accept;
  logic              drain_step;
  logic              can_push;
  logic [CmpW-1:0]   eff_size;
  logic [CmpW-1:0]   size_ext;
  logic [CmpW-1:0]   count_ext;
  logic [CmpW-1:0]   cnt_inc;
  logic              closes;
  stack_op_t         stack_op;

  logic [ValueW-1:0] cell_value [MAX_GROUP];

  // Effective group size: zero counts as one, clamp to the stack depth
  assign size_ext  = CmpW'(size_q);
  assign count_ext = CmpW'(count_q);
  always_comb begin
    eff_size = size_ext;
    if (size_ext == '0) begin
      eff_size = OneC;
    end else if (size_ext > MaxGroupC) begin
      eff_size = MaxGroupC;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign can_push  = count_ext < MaxGroupC;
  assign cnt_inc   = (!phase_q && !can_push) ? count_ext : count_ext + OneC;
  assign closes    = (cnt_inc >= eff_size) || list_end_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StAccept: begin
        if (accept && !phase_q && closes) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (slot_free && remain_q == CntW'(1)) begin
          state_d = StAccept;
        end
      end
      default: state_d = StAccept;
    endcase
  end

  // Handshake and stack control
  always_comb begin
    in_ready_o    = 1'b0;
    drain_step    = 1'b0;
    stack_op.push = 1'b0;
    stack_op.pop  = 1'b0;
    unique case (state_q)
      StAccept: begin
        in_ready_o    = slot_free;
        stack_op.push = in_valid_i && slot_free && !phase_q && can_push;
      end
      StDrain: begin
        drain_step   = slot_free;
        stack_op.pop = slot_free;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    count_d     = count_q;
    phase_d     = phase_q;
    remain_d    = remain_q;
    end_flag_d  = end_flag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    run_last_d  = run_last_q;
    out_end_d   = out_end_q;
    if (accept) begin
      if (!phase_q) begin
        if (closes) begin
          remain_d   = CntW'(cnt_inc);
          end_flag_d = list_end_i;
          count_d    = '0;
          phase_d    = !list_end_i;
        end else begin
          count_d = CntW'(cnt_inc);
        end
      end else begin
        out_valid_d = 1'b1;
        out_value_d = item_value_i;
        run_last_d  = 1'b1;
        out_end_d   = list_end_i;
        if (closes) begin
          count_d = '0;
          phase_d = 1'b0;
        end else begin
          count_d = CntW'(cnt_inc);
        end
      end
    end
    if (drain_step) begin
      out_valid_d = 1'b1;
      out_value_d = cell_value[0];
      run_last_d  = remain_q == CntW'(1);
      out_end_d   = end_flag_q && (remain_q == CntW'(1));
      remain_d    = remain_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAccept;
      size_q      <= GroupSizeReset;
      count_q     <= '0;
      phase_q     <= 1'b0;
      remain_q    <= '0;
      end_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      phase_q     <= phase_d;
      remain_q    <= remain_d;
      end_flag_q  <= end_flag_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    run_last_q  <= run_last_d;
    out_end_q   <= out_end_d;
  end

  // Stack as a chain of cells: newest value sits at the head
  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic [ValueW-1:0] prev_val;
    logic [ValueW-1:0] next_val;
    if (i == 0) begin : g_head
      assign prev_val = item_value_i;
    end else begin : g_body
      assign prev_val = cell_value[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_tail
      assign next_val = cell_value[i];
    end else begin : g_inner
      assign next_val = cell_value[i+1];
    end
    agr_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (stack_op),
      .prev_i  (prev_val),
      .next_i  (next_val),
      .value_o (cell_value[i])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign run_last_o     = run_last_q;
  assign out_list_end_o = out_end_q;

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> (remain_q != '0))
    else $error("drain with empty stack");

  a_op_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stack_op.push && stack_op.pop))
    else $error("push and pop together");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CmpW'(count_q) <= MaxGroupC) && (CmpW'(remain_q) <= MaxGroupC))
    else $error("count beyond stack depth");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && list_end_i) |=> (count_q == '0 && !phase_q))
    else $error("list end did not clear phase and count");

  a_drain_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> !in_ready_o)
    else $error("input taken during drain");

endmodule

`default_nettype wire

// ===== bench/alternate_group_reverser_unit_tb.sv =====
`timescale 1ns / 1ps

module alternate_group_reverser_unit_tb;
  import agr_pkg::*;

  localparam int unsigned MaxGroup    = 16;
  localparam int unsigned DrainCycles = 2 * MaxGroup + 8;
  localparam int unsigned RandomItems = 410;
  localparam int unsigned LongHold    = 300;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } list_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     run_last;
    logic                     list_end;
  } reordered_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [GroupSizeW-1:0]    cfg_wdata_i    = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic signed [ValueW-1:0] item_value_i   = '0;
  logic                     list_end_i     = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic signed [ValueW-1:0] out_value_o;
  logic                     run_last_o;
  logic                     out_list_end_o;

  alternate_group_reverser_unit #(
    .MAX_GROUP (MaxGroup)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .item_value_i   (item_value_i),
    .list_end_i     (list_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .run_last_o     (run_last_o),
    .out_list_end_o (out_list_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state
  logic [GroupSizeW-1:0]    group_size_cfg = GroupSizeReset;
  logic signed [ValueW-1:0] group_stack_m [MaxGroup];
  int unsigned              group_count_m  = 0;
  logic                     passing_m      = 1'b0;

  list_item_t pending_items [$];
  reordered_t reordered_q [$];

  int   err_count   = 0;
  logic in_fire_q   = 1'b0;
  logic out_fire_q  = 1'b0;
  int   tx_wait     = 0;
  int   rx_wait     = 0;
  int   rx_hold     = 0;
  int   rx_hold_req = 0;
  logic tx_burst    = 1'b0;
  logic rx_burst    = 1'b0;

  function automatic void reorder_item(logic signed [ValueW-1:0] v, logic e);
    int unsigned g;
    int          i;
    reordered_t  r;
    g = 32'(group_size_cfg);
    if (g < 1) g = 1;
    if (g > MaxGroup) g = MaxGroup;
    if (!passing_m) begin
      if (group_count_m < MaxGroup) begin
        group_stack_m[group_count_m] = v;
        group_count_m++;
      end
      // close the reversing group: emit newest first
      if (group_count_m >= g || e) begin
        for (i = int'(group_count_m) - 1; i >= 0; i--) begin
          r.value    = group_stack_m[i];
          r.run_last = (i == 0);
          r.list_end = (i == 0) && e;
          reordered_q.push_back(r);
        end
        group_count_m = 0;
        passing_m     = 1'b1;
      end
    end else begin
      r.value    = v;
      r.run_last = 1'b1;
      r.list_end = e;
      reordered_q.push_back(r);
      group_count_m++;
      if (group_count_m >= g) begin
        group_count_m = 0;
        passing_m     = 1'b0;
      end
    end
    if (e) begin
      group_count_m = 0;
      passing_m     = 1'b0;
    end
  endfunction

  // Monitor: record input transactions and check results
  always @(posedge clk_i) begin
    reordered_t exp_r;
    in_fire_q  <= rst_ni && in_valid_i && in_ready_o;
    out_fire_q <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reordered_q.size() == 0) begin
        $error("result with nothing expected: out_value %0d", out_value_o);
        err_count++;
      end else begin
        exp_r = reordered_q.pop_front();
        if (out_value_o !== exp_r.value) begin
          $error("out_value: expected %0d, actual %0d", exp_r.value, out_value_o);
          err_count++;
        end
        if (run_last_o !== exp_r.run_last) begin
          $error("run_last: expected %0b, actual %0b", exp_r.run_last, run_last_o);
          err_count++;
        end
        if (out_list_end_o !== exp_r.list_end) begin
          $error("out_list_end: expected %0b, actual %0b", exp_r.list_end, out_list_end_o);
          err_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) reorder_item(item_value_i, list_end_i);
  end

  // Driver: offer pending items, hold each until its transaction
  always @(negedge clk_i) begin
    list_item_t nxt;
    logic       drive_v;
    if (rst_ni && (!in_valid_i || in_fire_q)) begin
      if (in_fire_q) tx_wait = tx_burst ? 0 : $urandom_range(0, 16);
      drive_v = 1'b0;
      if (tx_wait > 0) begin
        tx_wait--;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        item_value_i <= nxt.value;
        list_end_i   <= nxt.last;
        drive_v = 1'b1;
      end
      in_valid_i <= drive_v;
    end
  end

  // Receiver: per-result back-pressure plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req > 0) begin
        rx_hold     = rx_hold_req;
        rx_hold_req = 0;
      end
      if (out_fire_q) rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic signed [ValueW-1:0] draw_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(input logic signed [ValueW-1:0] v, input logic e);
    list_item_t it;
    it.value = v;
    it.last  = e;
    pending_items.push_back(it);
  endtask

  // Queue a list of random values, marking the end unless the list is cut short
  task automatic queue_list(input int unsigned len, input logic with_end);
    int unsigned k;
    for (k = 0; k < len; k++) queue_item(draw_value(), with_end && (k == len - 1));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || reordered_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_group_size(input logic [GroupSizeW-1:0] sz);
    @(negedge clk_i);
    cfg_wdata_i <= sz;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    group_size_cfg = sz;
    @(posedge clk_i);
  endtask

  function automatic logic [GroupSizeW-1:0] draw_group_size();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd16;
      2: return GroupSizeW'($urandom_range(17, 31));
      3: return 5'd31;
      4: return 5'd1;
      default: return GroupSizeW'($urandom_range(2, 6));
    endcase
  endfunction

  initial begin
    int unsigned           rand_items;
    int unsigned           nlists;
    int unsigned           len;
    int unsigned           eff;
    int unsigned           l;
    int unsigned           k;
    logic [GroupSizeW-1:0] sz;
    logic                  cut_short;
    logic                  first_phase;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Example list at the reset group size of three
    for (k = 1; k <= 11; k++) queue_item(k, k == 11);
    // Value extremes, then a list of one item
    queue_item(32'sh8000_0000, 1'b0);
    queue_item(32'sh7FFF_FFFF, 1'b0);
    queue_item('0, 1'b0);
    queue_item(-32'sd1, 1'b1);
    queue_item(32'sh5555_AAAA, 1'b1);
    wait_drained();

    // Size zero behaves as one
    write_group_size(5'd0);
    queue_list(3, 1'b1);
    wait_drained();

    // Shrink the size in the middle of a reversing group
    write_group_size(5'd5);
    queue_list(3, 1'b0);
    wait_drained();
    write_group_size(5'd2);
    queue_list(1, 1'b0);
    wait_drained();

    rand_items  = 0;
    first_phase = 1'b1;
    while (rand_items < RandomItems) begin
      sz = draw_group_size();
      write_group_size(sz);
      eff = (sz == 0) ? 1 : (sz > MaxGroup) ? MaxGroup : 32'(sz);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (first_phase) begin
        // stall the output so the block fills and holds off its input
        tx_burst    = 1'b1;
        rx_hold_req = LongHold;
      end
      nlists    = $urandom_range(2, 5);
      cut_short = ($urandom_range(0, 3) == 0);
      for (l = 0; l < nlists; l++) begin
        // a long first list keeps items queued behind the stalled output
        len = (first_phase && l == 0) ? 3 * eff + 1 : $urandom_range(1, 3 * eff + 1);
        queue_list(len, !(cut_short && l == nlists - 1));
        rand_items += len;
        if (first_phase && l == 0) wait_drained();
      end
      first_phase = 1'b0;
      wait_drained();
    end

    wait_drained();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/agr_pkg.sv
hw/rtl/agr_cell.sv
hw/rtl/alternate_group_reverser_unit.sv
bench/alternate_group_reverser_unit_tb.sv
